FILE: rtl/core/mchw_pkg.sv
// Shared types and constants of the heartbeat watchdog core.
// Operation, status and fault codes, the control state type and the memory write group.
// No dependencies; every other file of the core imports this package.
package mchw_pkg;

    // Default sizes of the slot table.
    localparam int DEF_SLOTS        = 16;
    localparam int DEF_TIME_BITS    = 32;
    localparam int DEF_TIMEOUT_BITS = 20;

    // Widths of the fields on the stream ports.
    localparam int OP_W       = 3;
    localparam int ID_W       = 5;
    localparam int TMO_IN_W   = 20;
    localparam int NOW_IN_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int FAULT_W    = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;

    // Operation codes carried in tuser.
    localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
    localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
    localparam logic [OP_W-1:0] OP_HEARTBEAT  = 3'd2;
    localparam logic [OP_W-1:0] OP_CRITICAL   = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK      = 3'd4;
    localparam logic [OP_W-1:0] OP_STOP       = 3'd5;

    // Status codes of a result word.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STOPPED = 2'd3;

    // Check outcomes.
    localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_TIMEOUT  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_CRITICAL = 2'd2;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FIND,
        S_WALK,
        S_EMIT
    } state_t;

    // Write enables of the two slot memories.
    typedef struct packed {
        logic tmo_we;
        logic seen_we;
    } mem_wr_t;

endpackage

FILE: rtl/core/mchw_slot_mem.sv
// Slot memories of the heartbeat watchdog: per-slot timeout and last-seen time.
// Synchronous write, registered synchronous read enabled by rd_en; uses mchw_pkg.
module mchw_slot_mem
    import mchw_pkg::*;
#(
    parameter int SLOTS        = DEF_SLOTS,
    parameter int TIME_BITS    = DEF_TIME_BITS,
    parameter int TIMEOUT_BITS = DEF_TIMEOUT_BITS,
    parameter int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic                    clk,
    input  mem_wr_t                 wr,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic [TIMEOUT_BITS-1:0] wr_tmo,
    input  logic [TIME_BITS-1:0]    wr_seen,
    input  logic                    rd_en,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic [TIMEOUT_BITS-1:0] rd_tmo,
    output logic [TIME_BITS-1:0]    rd_seen
);

    logic [TIMEOUT_BITS-1:0] tmo_mem  [SLOTS];
    logic [TIME_BITS-1:0]    seen_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.tmo_we)
        begin
            tmo_mem[wr_addr] <= wr_tmo;
        end
        if (wr.seen_we)
        begin
            seen_mem[wr_addr] <= wr_seen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tmo  <= tmo_mem[rd_addr];
            rd_seen <= seen_mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/multi_client_heartbeat_watchdog_core.sv
// Heartbeat watchdog core: a table of client slots checked against their timeouts.
// Unregister, heartbeat, critical error, stop and unknown words are decoded and answered;
// a register scans the slots from slot 1 upward for the first free one (full when none is);
// a check walks the slots one per cycle through the slot memory read port unless stopped.
// One word is in work at a time; the next word is taken in the cycle after the result is
// registered, and a result waits until the output register is free or being taken.
// Reset clears all valid and critical flags and the stopped state; memories need no clearing.
module multi_client_heartbeat_watchdog_core
    import mchw_pkg::*;
#(
    parameter int SLOTS        = DEF_SLOTS,
    parameter int TIME_BITS    = DEF_TIME_BITS,
    parameter int TIMEOUT_BITS = DEF_TIMEOUT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input words.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: module_id[4:0], timeout_ms[24:5], now_ms[56:25], zero pad[63:57].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser from bit 0: operation[2:0].
    input  logic [OP_W-1:0]       s_axis_tuser,
    // Result words.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0: status[1:0], slot_out[6:2], kick[7], fault[9:8], zero pad[15:10].
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Slot index width and the width of the slot count, which can hold SLOTS itself.
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;
    // Width in which the elapsed time is compared against a timeout.
    localparam int CMP_W = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;
    // Width in which a module id is range checked against the slot count.
    localparam int ID_CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;
    localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [ID_CMP_W-1:0] SLOT_LIM  = ID_CMP_W'(SLOTS);
    localparam int                  OUT_USED  = STATUS_W + ID_W + 1 + FAULT_W;

    // Control state.
    state_t state_reg, state_next;

    // Slot flags kept in flip-flops so that reset clears them at once.
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] crit_reg, crit_next;
    logic             stopped_reg, stopped_next;

    // Captured input word.
    logic [OP_W-1:0]         op_reg;
    logic [ID_W-1:0]         id_reg;
    logic [TIMEOUT_BITS-1:0] tmo_reg;
    logic [TIME_BITS-1:0]    now_reg;

    // Slot walk: read pointer, end-of-read flag and the slot whose read data is due.
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_done_reg, rd_done_next;
    logic             eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;

    // Result being built.
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_slot_reg, res_slot_next;
    logic                res_kick_reg, res_kick_next;
    logic [FAULT_W-1:0]  res_fault_reg, res_fault_next;

    // Output register that parts the result side from the work.
    logic                  out_vld_reg, out_vld_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Memory ports.
    mem_wr_t                 mem_wr;
    logic [IDX_W-1:0]        mem_wr_addr;
    logic                    mem_rd_en;
    logic [TIMEOUT_BITS-1:0] mem_rd_tmo;
    logic [TIME_BITS-1:0]    mem_rd_seen;

    // Helpers.
    logic                 in_acc;
    logic                 out_load;
    logic                 id_ok;
    logic [IDX_W-1:0]     id_idx;
    logic [TIME_BITS-1:0] elapsed;
    logic                 expired;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // A module id names a slot when it is between 1 and SLOTS and that slot is in use.
    assign id_idx = IDX_W'(id_reg - ID_W'(1));
    assign id_ok  = (id_reg != '0) && (ID_CMP_W'(id_reg) <= SLOT_LIM) && valid_reg[id_idx];

    // Silence of the slot under evaluation, wrapped at the time width.
    assign elapsed = now_reg - mem_rd_seen;
    assign expired = CMP_W'(elapsed) > CMP_W'(mem_rd_tmo);

    // The result moves to the output register once the old one is gone or being taken.
    assign out_load = (state_reg == S_EMIT) && (!out_vld_reg || m_axis_tready);

    // Timeout and last-seen times live in the slot memories. A check only reads them and
    // the table operations only write them, and one word is in work at a time, so a write
    // is always done before any read of the same entry.
    mchw_slot_mem
    #(
        .SLOTS        (SLOTS),
        .TIME_BITS    (TIME_BITS),
        .TIMEOUT_BITS (TIMEOUT_BITS),
        .IDX_W        (IDX_W)
    )
    u_slot_mem
    (
        .clk     (clk),
        .wr      (mem_wr),
        .wr_addr (mem_wr_addr),
        .wr_tmo  (tmo_reg),
        .wr_seen (now_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_idx_reg),
        .rd_tmo  (mem_rd_tmo),
        .rd_seen (mem_rd_seen)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_REGISTER:
                    begin
                        state_next = S_FIND;
                    end
                    OP_CHECK:
                    begin
                        state_next = stopped_reg ? S_EMIT : S_WALK;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_FIND:
            begin
                if (!valid_reg[rd_idx_reg] || (rd_idx_reg == LAST_IDX))
                begin
                    state_next = S_EMIT;
                end
            end
            S_WALK:
            begin
                if (eval_vld_reg && (eval_idx_reg == LAST_IDX || (valid_reg[eval_idx_reg]
                    && (crit_reg[eval_idx_reg] || expired))))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_rd_en     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_WALK:
            begin
                mem_rd_en = !rd_done_reg;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Table updates, slot walk and result.
    always_comb
    begin
        valid_next      = valid_reg;
        crit_next       = crit_reg;
        stopped_next    = stopped_reg;
        rd_idx_next     = rd_idx_reg;
        rd_done_next    = rd_done_reg;
        eval_vld_next   = 1'b0;
        eval_idx_next   = eval_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_kick_next   = res_kick_reg;
        res_fault_next  = res_fault_reg;
        mem_wr          = '0;
        mem_wr_addr     = rd_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                res_status_next = ST_OK;
                res_slot_next   = '0;
                res_kick_next   = 1'b0;
                res_fault_next  = FAULT_NONE;
                rd_idx_next     = '0;
                rd_done_next    = 1'b0;
            end
            S_EXEC:
            begin
                mem_wr_addr = id_idx;
                case (op_reg)
                    OP_UNREGISTER:
                    begin
                        if (!id_ok)
                        begin
                            res_status_next = ST_BAD;
                        end
                        else
                        begin
                            valid_next[id_idx] = 1'b0;
                            crit_next[id_idx]  = 1'b0;
                        end
                    end
                    OP_HEARTBEAT:
                    begin
                        if (!id_ok)
                        begin
                            res_status_next = ST_BAD;
                        end
                        else
                        begin
                            mem_wr.seen_we = 1'b1;
                        end
                    end
                    OP_CRITICAL:
                    begin
                        if (!id_ok)
                        begin
                            res_status_next = ST_BAD;
                        end
                        else
                        begin
                            crit_next[id_idx] = 1'b1;
                        end
                    end
                    OP_CHECK:
                    begin
                        if (stopped_reg)
                        begin
                            res_status_next = ST_STOPPED;
                        end
                    end
                    OP_STOP:
                    begin
                        if (stopped_reg)
                        begin
                            res_status_next = ST_STOPPED;
                        end
                        stopped_next = 1'b1;
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_FIND:
            begin
                if (!valid_reg[rd_idx_reg])
                begin
                    mem_wr.tmo_we          = 1'b1;
                    mem_wr.seen_we         = 1'b1;
                    valid_next[rd_idx_reg] = 1'b1;
                    crit_next[rd_idx_reg]  = 1'b0;
                    res_status_next        = ST_OK;
                    res_slot_next          = ID_W'(CNT_W'(rd_idx_reg) + CNT_W'(1));
                end
                else if (rd_idx_reg == LAST_IDX)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            S_WALK:
            begin
                if (!rd_done_reg)
                begin
                    eval_vld_next = 1'b1;
                    eval_idx_next = rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
                if (eval_vld_reg)
                begin
                    if (valid_reg[eval_idx_reg] && (crit_reg[eval_idx_reg] || expired))
                    begin
                        // A critical flag outranks a timeout on the same slot.
                        res_fault_next = crit_reg[eval_idx_reg] ? FAULT_CRITICAL
                                                                : FAULT_TIMEOUT;
                        res_slot_next  = ID_W'(CNT_W'(eval_idx_reg) + CNT_W'(1));
                        stopped_next   = 1'b1;
                        eval_vld_next  = 1'b0;
                    end
                    else if (eval_idx_reg == LAST_IDX)
                    begin
                        res_kick_next = 1'b1;
                        eval_vld_next = 1'b0;
                    end
                end
            end
            default:
            begin
                eval_vld_next = 1'b0;
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            crit_reg       <= '0;
            stopped_reg    <= 1'b0;
            rd_done_reg    <= 1'b0;
            eval_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            crit_reg       <= crit_next;
            stopped_reg    <= stopped_next;
            rd_done_reg    <= rd_done_next;
            eval_vld_reg   <= eval_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg  <= s_axis_tuser;
            id_reg  <= s_axis_tdata[ID_W-1:0];
            tmo_reg <= TIMEOUT_BITS'(s_axis_tdata[ID_W +: TMO_IN_W]);
            now_reg <= TIME_BITS'(s_axis_tdata[ID_W + TMO_IN_W +: NOW_IN_W]);
        end
        rd_idx_reg     <= rd_idx_next;
        eval_idx_reg   <= eval_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_kick_reg   <= res_kick_next;
        res_fault_reg  <= res_fault_next;
        if (out_load)
        begin
            out_data_reg <= {(OUT_DATA_W - OUT_USED)'(0), res_fault_reg, res_kick_reg,
                             res_slot_reg, res_status_reg};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // The slot walk only reads the memories.
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !(mem_wr.tmo_we || mem_wr.seen_we))
        else $error("slot memory written during a check walk");

    // A kick never comes with a fault or a failing slot.
    a_kick_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_kick_reg) |-> (res_fault_reg == FAULT_NONE && res_slot_reg == '0))
        else $error("kick issued together with a fault");

    // A reported fault leaves the monitor stopped.
    a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_fault_reg != FAULT_NONE) |-> stopped_reg)
        else $error("fault reported without latching the stopped state");

    // Only reset leaves the stopped state.
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stopped state cleared without reset");

    // An accepted word is decoded in the next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_EXEC))
        else $error("accepted word not decoded");

endmodule

FILE: verif/multi_client_heartbeat_watchdog_core_tb.sv
// Self-checking testbench for the heartbeat watchdog core: a stream driver, a result monitor
// and a slot-table predictor that mirrors the core's handling of every operation.
// Depends on mchw_pkg and multi_client_heartbeat_watchdog_core only.
`timescale 1ns / 1ps

module multi_client_heartbeat_watchdog_core_tb;
    import mchw_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    // The two operation codes that the core leaves unused.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     module_id;
        logic [TMO_IN_W-1:0] timeout_ms;
        logic [NOW_IN_W-1:0] now_ms;
    } hb_cmd_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     slot_out;
        logic                kick;
        logic [FAULT_W-1:0]  fault;
    } hb_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Predicted contents of the slot table and the latched stopped state.
    bit                  slot_live  [DEF_SLOTS];
    logic [TMO_IN_W-1:0] slot_limit [DEF_SLOTS];
    logic [NOW_IN_W-1:0] slot_seen  [DEF_SLOTS];
    bit                  slot_alarm [DEF_SLOTS];
    bit                  wd_halted;

    hb_cmd_t   cmd_backlog[$];
    hb_reply_t reply_expect[$];
    hb_cmd_t   on_bus;
    logic [NOW_IN_W-1:0] wall_ms;

    int cycle_cnt = 0;
    int mismatches = 0;
    int words_taken = 0;
    int replies_seen = 0;
    int kicks_seen = 0;
    int faults_seen = 0;
    int full_seen = 0;
    int halted_seen = 0;

    multi_client_heartbeat_watchdog_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Run timed out after %0d cycles.", cycle_cnt);
            $display("[multi_client_heartbeat_watchdog_core] ERROR");
            $finish;
        end
    end

    // Each side pauses with a chance of 31 in a hundred, except in one long steady window.
    function automatic bit take_break();
        if (cycle_cnt >= 3000 && cycle_cnt < 6000)
            return 1'b0;
        return ($urandom_range(0, 99) < 31);
    endfunction

    // Applies one accepted word to the predicted table and returns the reply it must cause.
    function automatic hb_reply_t predict_reply(input hb_cmd_t c);
        hb_reply_t r;
        int idx;
        bit hit;
        logic [NOW_IN_W-1:0] silence;
        r.status = ST_OK;
        r.slot_out = '0;
        r.kick = 1'b0;
        r.fault = FAULT_NONE;
        hit = 1'b0;
        idx = int'(c.module_id) - 1;
        case (c.op)
            OP_REGISTER:
            begin
                r.status = ST_FULL;
                for (int i = 0; i < DEF_SLOTS; i++)
                begin
                    if (!hit && !slot_live[i])
                    begin
                        hit = 1'b1;
                        slot_live[i] = 1'b1;
                        slot_limit[i] = c.timeout_ms;
                        slot_seen[i] = c.now_ms;
                        slot_alarm[i] = 1'b0;
                        r.status = ST_OK;
                        r.slot_out = i[ID_W-1:0] + 1'b1;
                    end
                end
            end
            OP_UNREGISTER, OP_HEARTBEAT, OP_CRITICAL:
            begin
                if (idx < 0 || idx >= DEF_SLOTS || !slot_live[idx])
                    r.status = ST_BAD;
                else if (c.op == OP_UNREGISTER)
                begin
                    slot_live[idx] = 1'b0;
                    slot_alarm[idx] = 1'b0;
                end
                else if (c.op == OP_HEARTBEAT)
                    slot_seen[idx] = c.now_ms;
                else
                    slot_alarm[idx] = 1'b1;
            end
            OP_CHECK:
            begin
                if (wd_halted)
                    r.status = ST_STOPPED;
                else
                begin
                    // The walk stops at the first failing slot; a critical flag beats a timeout.
                    for (int i = 0; i < DEF_SLOTS; i++)
                    begin
                        if (!hit && slot_live[i])
                        begin
                            silence = c.now_ms - slot_seen[i];
                            if (slot_alarm[i])
                                r.fault = FAULT_CRITICAL;
                            else if (silence > {12'd0, slot_limit[i]})
                                r.fault = FAULT_TIMEOUT;
                            if (r.fault != FAULT_NONE)
                            begin
                                hit = 1'b1;
                                r.slot_out = i[ID_W-1:0] + 1'b1;
                            end
                        end
                    end
                    if (hit)
                        wd_halted = 1'b1;
                    else
                        r.kick = 1'b1;
                end
            end
            OP_STOP:
            begin
                if (wd_halted)
                    r.status = ST_STOPPED;
                wd_halted = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Input side: predicts each word as it is accepted, then presents the next one.
    always @(posedge clk)
    begin : word_driver
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                reply_expect.push_back(predict_reply(on_bus));
                words_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (cmd_backlog.size() != 0 && !take_break())
                begin
                    on_bus = cmd_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {7'd0, on_bus.now_ms, on_bus.timeout_ms, on_bus.module_id};
                    s_axis_tuser <= on_bus.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side: compares every accepted result word with the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        hb_reply_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (reply_expect.size() == 0)
                begin
                    $error("result word 0x%h arrived with no prediction pending", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = reply_expect.pop_front();
                    replies_seen++;
                    check_field("status", int'(want.status), int'(m_axis_tdata[1:0]));
                    check_field("slot_out", int'(want.slot_out), int'(m_axis_tdata[6:2]));
                    check_field("kick", int'(want.kick), int'(m_axis_tdata[7]));
                    check_field("fault", int'(want.fault), int'(m_axis_tdata[9:8]));
                    if (want.kick)
                        kicks_seen++;
                    if (want.fault != FAULT_NONE)
                        faults_seen++;
                    if (want.status == ST_FULL)
                        full_seen++;
                    if (want.status == ST_STOPPED)
                        halted_seen++;
                end
            end
            m_axis_tready <= !take_break();
        end
    end

    task automatic post(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                        input logic [TMO_IN_W-1:0] tmo, input logic [NOW_IN_W-1:0] now);
        hb_cmd_t c;
        c.op = op;
        c.module_id = id;
        c.timeout_ms = tmo;
        c.now_ms = now;
        cmd_backlog.push_back(c);
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0)
            @(posedge clk);
    endtask

    // Mostly a slot that is registered right now, else any id from 0 to DEF_SLOTS.
    function automatic logic [ID_W-1:0] pick_slot();
        int k;
        for (int n = 0; n < DEF_SLOTS; n++)
        begin
            k = $urandom_range(0, DEF_SLOTS - 1);
            if (slot_live[k])
                return k[ID_W-1:0] + 1'b1;
        end
        return ID_W'($urandom_range(0, DEF_SLOTS));
    endfunction

    // In the live phase time creeps forward and timeouts are long, so checks keep passing;
    // in the wild phase every field is random and every operation may come.
    task automatic queue_random(input int count, input bit wild);
        int roll;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic [TMO_IN_W-1:0] tmo;
        logic [NOW_IN_W-1:0] now;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            id = ID_W'($urandom_range(0, DEF_SLOTS));
            tmo = TMO_IN_W'($urandom_range(0, 20'hFFFFF));
            if (wild)
            begin
                now = $urandom;
                op = OP_W'($urandom_range(0, 7));
                if ((op == OP_UNREGISTER || op == OP_HEARTBEAT || op == OP_CRITICAL)
                    && roll < 70)
                    id = pick_slot();
                post(op, id, tmo, now);
            end
            else
            begin
                wall_ms = wall_ms + $urandom_range(0, 7);
                now = wall_ms;
                if (roll < 22)
                    post(OP_REGISTER, id, TMO_IN_W'($urandom_range(32'h20000, 32'hFFFFF)), now);
                else if (roll < 37)
                    post(OP_UNREGISTER, (roll % 5 != 0) ? pick_slot() : id, tmo, now);
                else if (roll < 67)
                    post(OP_HEARTBEAT, (roll % 5 != 0) ? pick_slot() : id, tmo, now);
                else if (roll < 85)
                    post(OP_CHECK, id, tmo, now);
                else if (roll < 93)
                begin
                    // A critical mark that is withdrawn at once, so no check ever sees it.
                    id = pick_slot();
                    post(OP_CRITICAL, id, tmo, now);
                    post(OP_UNREGISTER, id, tmo, now);
                end
                else if (roll < 96)
                    post(OP_CRITICAL, 5'd0, tmo, now);
                else
                    post((roll % 2) ? OP_SPARE_A : OP_SPARE_B, id, tmo, now);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [NOW_IN_W-1:0] t0;
        int scenario;
        for (int i = 0; i < DEF_SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_limit[i] = '0;
            slot_seen[i] = '0;
            slot_alarm[i] = 1'b0;
        end
        wd_halted = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening, just before the 32-bit time wrap.
        t0 = 32'hFFFF_FFE0;
        post(OP_CHECK, 5'd31 & 5'd16, 20'd0, t0);          // empty table passes
        post(OP_UNREGISTER, 5'd0, 20'hFFFFF, t0);           // id zero is out of range
        post(OP_HEARTBEAT, 5'd16, 20'd0, t0);               // highest id, not yet used
        post(OP_CRITICAL, 5'd1, 20'd0, t0);
        post(OP_REGISTER, 5'd0, 20'h00020, t0);             // slot 1 gets a short timeout
        for (int i = 1; i < DEF_SLOTS; i++)
            post(OP_REGISTER, ID_W'($urandom_range(0, DEF_SLOTS)), 20'hFFFFF, t0);
        post(OP_REGISTER, 5'd16, 20'hFFFFF, t0);            // table full
        post(OP_UNREGISTER, 5'd16, 20'd0, t0);
        post(OP_UNREGISTER, 5'd3, 20'd0, t0);
        post(OP_REGISTER, 5'd0, 20'hFFFFF, t0);             // lowest free slot is 3
        post(OP_CRITICAL, 5'd4, 20'd0, t0);
        post(OP_UNREGISTER, 5'd4, 20'd0, t0);               // clears the critical mark
        post(OP_REGISTER, 5'd0, 20'hFFFFF, t0);
        post(OP_HEARTBEAT, 5'd2, 20'd0, 32'hFFFF_FFFF);
        // Wraps to zero: slot 1 has been silent exactly as long as it may be.
        post(OP_CHECK, 5'd0, 20'd0, 32'h0000_0000);
        post(OP_SPARE_A, 5'd16, 20'hFFFFF, 32'hFFFF_FFFF);
        post(OP_SPARE_B, 5'd0, 20'd0, 32'h0000_0000);
        post(OP_UNREGISTER, 5'd1, 20'd0, 32'h0000_0000);
        wall_ms = 32'h0000_0000;
        drain();

        // Live phase: checks pass while the table churns.
        for (int n = 0; n < 88; n++)
        begin
            queue_random(16, 1'b0);
            drain();
        end

        // Only one check can ever fail because the stopped state never clears,
        // so the seed picks which way the monitor gets stopped.
        for (int i = 1; i <= DEF_SLOTS; i++)
            post(OP_UNREGISTER, i[ID_W-1:0], 20'd0, wall_ms);
        post(OP_REGISTER, 5'd0, 20'd0, wall_ms);
        post(OP_REGISTER, 5'd0, 20'd5, wall_ms);
        post(OP_REGISTER, 5'd0, 20'd3, wall_ms);
        post(OP_HEARTBEAT, 5'd1, 20'd0, wall_ms + 6);
        scenario = $urandom_range(0, 2);
        if (scenario == 1)
        begin
            post(OP_CRITICAL, 5'd2, 20'd0, wall_ms + 6);
            post(OP_CRITICAL, 5'd3, 20'd0, wall_ms + 6);
        end
        else if (scenario == 2)
            post(OP_STOP, 5'd0, 20'd0, wall_ms + 6);
        // Slot 2 times out (and carries a critical mark in one scenario); slot 3 fails too.
        post(OP_CHECK, 5'd0, 20'd0, wall_ms + 6);
        post(OP_CHECK, 5'd0, 20'd0, wall_ms + 7);
        post(OP_STOP, 5'd0, 20'd0, wall_ms + 7);
        post(OP_REGISTER, 5'd0, 20'hFFFFF, wall_ms + 7);   // table still works when stopped
        drain();

        // Wild phase after the stop.
        for (int n = 0; n < 22; n++)
        begin
            queue_random(16, 1'b1);
            drain();
        end

        while (cmd_backlog.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (reply_expect.size() != 0)
            @(posedge clk);
        repeat (3 * (DEF_SLOTS + 3)) @(posedge clk);
        if (reply_expect.size() != 0)
        begin
            $error("%0d predicted results never arrived", reply_expect.size());
            mismatches++;
        end

        $display("Sent %0d words, checked %0d results (failure path %0d).",
                 words_taken, replies_seen, scenario);
        $display("Seen: %0d kicks, %0d check faults, %0d full-table and %0d stopped answers.",
                 kicks_seen, faults_seen, full_seen, halted_seen);
        if (mismatches == 0)
            $display("[multi_client_heartbeat_watchdog_core] OK");
        else
            $display("[multi_client_heartbeat_watchdog_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/mchw_pkg.sv
rtl/core/mchw_slot_mem.sv
rtl/core/multi_client_heartbeat_watchdog_core.sv
verif/multi_client_heartbeat_watchdog_core_tb.sv
